// ===== rtl/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants of the charlieplex display scanner
// Register indexes, LED maps of the scan and the configuration bundle.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned NumPins  = 6;
  localparam int unsigned StepW    = 5;
  localparam int unsigned LedW     = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  localparam logic [StepW-1:0] ScanLen  = 5'd22;
  localparam logic [StepW-1:0] LastStep = 5'd21;

  // scan step boundaries
  localparam logic [StepW-1:0] StepRight     = 5'd7;
  localparam logic [StepW-1:0] StepPuddleA   = 5'd14;
  localparam logic [StepW-1:0] StepPuddleB   = 5'd15;
  localparam logic [StepW-1:0] StepPercent   = 5'd16;
  localparam logic [StepW-1:0] StepLightning = 5'd17;
  localparam logic [StepW-1:0] StepDrop      = 5'd18;

  localparam logic [LedW-1:0] LedPercent   = 5'd16;
  localparam logic [LedW-1:0] LedLightning = 5'd17;
  localparam logic [LedW-1:0] LedDropBase  = 5'd20;

  localparam logic [2:0] NumPuddleFrames = 3'd5;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegLeftSegments  = 3'd0,
    RegRightSegments = 3'd1,
    RegPuddleFrame   = 3'd2,
    RegPercentOn     = 3'd3,
    RegLightningOn   = 3'd4,
    RegDropPattern   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [6:0] left_segments;
    logic [6:0] right_segments;
    logic [2:0] puddle_frame;
    logic       percent_on;
    logic       lightning_on;
    logic [3:0] drop_pattern;
  } cfg_t;

  typedef logic [LedW-1:0] led_t;

  localparam led_t LeftMap  [7] = '{5'd11, 5'd6, 5'd12, 5'd7, 5'd8, 5'd13, 5'd18};
  localparam led_t RightMap [7] = '{5'd5, 5'd0, 5'd10, 5'd1, 5'd15, 5'd2, 5'd3};
  localparam led_t PuddleMap [5][2] = '{
    '{5'd26, 5'd27}, '{5'd27, 5'd28}, '{5'd28, 5'd29}, '{5'd29, 5'd25}, '{5'd25, 5'd26}
  };

endpackage

// ===== rtl/cds_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cds_cfg_regs: configuration register file
// Takes register writes by index; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module cds_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cds_pkg::CfgDataW-1:0]  cfg_data_i,
  output cds_pkg::cfg_t                 cfg_o
);
  import cds_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegLeftSegments:  cfg_d.left_segments  = cfg_data_i[6:0];
        RegRightSegments: cfg_d.right_segments = cfg_data_i[6:0];
        RegPuddleFrame:   cfg_d.puddle_frame   = cfg_data_i[2:0];
        RegPercentOn:     cfg_d.percent_on     = cfg_data_i[0];
        RegLightningOn:   cfg_d.lightning_on   = cfg_data_i[0];
        RegDropPattern:   cfg_d.drop_pattern   = cfg_data_i[3:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/cds_led_encode.sv =====
// ----------------------------------------------------------------------------
// cds_led_encode: scan step to pin drive pattern
// Picks the LED of a step from the maps and turns it into high/low pins.
// ----------------------------------------------------------------------------
module cds_led_encode (
  input  logic [cds_pkg::StepW-1:0]   step_i,
  input  cds_pkg::cfg_t               cfg_i,
  output logic [cds_pkg::NumPins-1:0] drive_enable_o,
  output logic [cds_pkg::NumPins-1:0] drive_level_o
);
  import cds_pkg::*;

  logic       lit;
  led_t       led;
  logic [2:0] idx;
  logic [1:0] drop_k;
  logic [2:0] hi;
  logic [2:0] lo;
  logic [4:0] rem;

  always_comb begin
    lit    = 1'b0;
    led    = '0;
    idx    = '0;
    drop_k = 2'(step_i - StepDrop);
    if (step_i < StepRight) begin
      idx = step_i[2:0];
      lit = cfg_i.left_segments[3'd6 - idx];
      led = LeftMap[idx];
    end else if (step_i < StepPuddleA) begin
      idx = 3'(step_i - StepRight);
      lit = cfg_i.right_segments[3'd6 - idx];
      led = RightMap[idx];
    end else if (step_i == StepPuddleA || step_i == StepPuddleB) begin
      lit = (cfg_i.puddle_frame < NumPuddleFrames);
      if (lit) led = PuddleMap[cfg_i.puddle_frame][step_i[0]];
    end else if (step_i == StepPercent) begin
      lit = cfg_i.percent_on;
      led = LedPercent;
    end else if (step_i == StepLightning) begin
      lit = cfg_i.lightning_on;
      led = LedLightning;
    end else if (step_i < ScanLen) begin
      lit = cfg_i.drop_pattern[drop_k];
      led = LedDropBase + LedW'(drop_k);
    end
  end

  // led / 5 and led % 5 by compare chain; low pin skips the high pin
  always_comb begin
    if      (led >= 5'd25) hi = 3'd5;
    else if (led >= 5'd20) hi = 3'd4;
    else if (led >= 5'd15) hi = 3'd3;
    else if (led >= 5'd10) hi = 3'd2;
    else if (led >= 5'd5)  hi = 3'd1;
    else                   hi = 3'd0;
    rem = led - 5'(hi) * 5'd5;
    lo  = rem[2:0];
    if (lo >= hi) lo = lo + 3'd1;
  end

  always_comb begin
    drive_enable_o = '0;
    drive_level_o  = '0;
    if (lit) begin
      drive_enable_o = (NumPins'(1) << hi) | (NumPins'(1) << lo);
      drive_level_o  = NumPins'(1) << hi;
    end
  end

endmodule

// ===== rtl/charlieplex_display_scanner_core.sv =====
// ----------------------------------------------------------------------------
// charlieplex_display_scanner_core: 22-step charlieplex LED scanner
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid_i/in_stall_o | tick_i
//   out     | output    | out_valid_o/out_stall_i | drive_enable_o, drive_level_o,
//           |           |                      | step_shown_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One tick per cycle while in_stall_o is low; a taken tick's step is registered
// in the step register, then drive-encoded into the output register.
// A transfer with tick low yields no result and leaves the scan in place.
// Reset clears the scan position, the configuration registers and both valid flags.
// A stalled output holds its data; input stalls only when both stages are full.
// ----------------------------------------------------------------------------
module charlieplex_display_scanner_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          tick_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cds_pkg::NumPins-1:0]   drive_enable_o,
  output logic [cds_pkg::NumPins-1:0]   drive_level_o,
  output logic [cds_pkg::StepW-1:0]     step_shown_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cds_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cds_pkg::*;

  cfg_t cfg;

  logic [StepW-1:0]   scan_q, scan_d;
  logic               s1_valid_q, s1_valid_d;
  logic [StepW-1:0]   s1_step_q;
  logic               out_valid_q, out_valid_d;
  logic [NumPins-1:0] enable_q, level_q;
  logic [StepW-1:0]   step_q;
  logic [NumPins-1:0] enc_enable, enc_level;
  logic               out_ready, s1_ready, in_xfer, tick_xfer;

  cds_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cds_led_encode u_led_encode (
    .step_i         (s1_step_q),
    .cfg_i          (cfg),
    .drive_enable_o (enc_enable),
    .drive_level_o  (enc_level)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_xfer    = in_valid_i && s1_ready;
  assign tick_xfer  = in_xfer && tick_i;

  always_comb begin
    scan_d = scan_q;
    if (tick_xfer) scan_d = (scan_q >= LastStep) ? '0 : scan_q + 5'd1;
    s1_valid_d = s1_ready ? tick_xfer : s1_valid_q;
    out_valid_d = out_ready ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      scan_q      <= scan_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_xfer) s1_step_q <= scan_q;
    if (out_ready && s1_valid_q) begin
      enable_q <= enc_enable;
      level_q  <= enc_level;
      step_q   <= s1_step_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_enable_o = enable_q;
  assign drive_level_o  = level_q;
  assign step_shown_o   = step_q;

  // a lit step drives exactly two pins, one of them high
  a_two_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones(enable_q) == 0 || $countones(enable_q) == 2))
    else $error("drive pattern does not drive zero or two pins");

  a_level_in_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((level_q & ~enable_q) == '0 && $onehot0(level_q)))
    else $error("high pin is not among driven pins");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q < ScanLen)
    else $error("scan position out of range");

  a_step_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && s1_valid_q) |=> (out_valid_q &&
      (step_q == ((($past(step_q)) >= LastStep) ? 5'd0 : $past(step_q) + 5'd1))))
    else $error("consecutive results skip a scan step");

endmodule
